FILE: rtl/tcphpm_pkg.sv
package tcphpm_pkg;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_UPDATED = 3'd1,
        ST_SKIPPED = 3'd2,
        ST_FULL    = 3'd3,
        ST_READ    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_READ_WAIT,
        FSM_SCAN_RD,
        FSM_SCAN_CMP
    } fsm_t;

    localparam logic       OP_BYTE        = 1'b0;
    localparam logic       OP_READ        = 1'b1;
    localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;
    localparam int          KEY_BITS      = 64;
    localparam int          OUT_TOTAL_BITS = 40;

endpackage

FILE: rtl/tcphpm_ram.sv
module tcphpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/tcp_host_pair_byte_matrix_unit.sv
// Per host-pair TCP payload byte counter.
// Command channel: an item is taken on a clock edge with start high and busy
// low. op = 0 carries one captured frame byte (last_byte marks the final
// one); op = 1 reads the table slot at entry_index.
// Result channel: done is high for exactly one cycle with status, src_addr,
// dst_addr, byte_total and entry_valid. The receiver cannot stall it.
// Timing: a frame byte that is not final gives no result and busy stays
// low. A final byte of a skipped frame gives its result on the next cycle,
// busy stays low. A slot read registers the RAM word and then the result,
// with busy high in FSM_READ_WAIT between the two. A counted frame scans
// the table through the single read port, through SCAN_RD and SCAN_CMP for
// each used entry, with busy high until the result arrives.
// Pairs fill the table in order, so slots below the fill count are valid and
// no clearing pass is needed. Reset empties the table and clears the frame
// parse at once.
module tcp_host_pair_byte_matrix_unit #(
    parameter int TABLE_ENTRIES = 256,
    parameter int TOTAL_BITS    = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         op,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic [7:0]   entry_index,
    output logic         done,
    output logic [2:0]   status,
    output logic [31:0]  src_addr,
    output logic [31:0]  dst_addr,
    output logic signed [39:0] byte_total,
    output logic         entry_valid
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int RW = tcphpm_pkg::KEY_BITS + TOTAL_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    tcphpm_pkg::fsm_t state_reg, state_next;

    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] ptr_reg, ptr_next;

    logic [15:0] offset_reg, offset_next;
    logic [15:0] ether_reg, ether_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] iplen_reg, iplen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] sport_reg, sport_next;
    logic [3:0]  thl_reg, thl_next;

    logic [63:0]       key_reg, key_next;
    logic signed [17:0] pay_reg, pay_next;
    logic              hit_reg, hit_next;

    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] osrc_reg, osrc_next;
    logic [31:0] odst_reg, odst_next;
    logic [39:0] otot_reg, otot_next;
    logic        ovalid_reg, ovalid_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    logic [15:0] tcp_at;
    logic        accept;
    logic signed [TOTAL_BITS-1:0] rd_total;
    logic signed [TOTAL_BITS-1:0] sum_total;
    logic signed [TOTAL_BITS-1:0] new_total;
    logic signed [63:0] rd_ext, sum_ext, new_ext;
    logic [15:0] ihl_bytes, thl_bytes;

    tcphpm_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept = start && (state_reg == tcphpm_pkg::FSM_IDLE);
    assign busy   = (state_reg != tcphpm_pkg::FSM_IDLE);

    // totals as stored, updated and shown
    assign rd_total  = ram_rdata[TOTAL_BITS-1:0];
    assign sum_total = rd_total + TOTAL_BITS'(pay_reg);
    assign new_total = TOTAL_BITS'(pay_reg);
    assign rd_ext    = 64'(rd_total);
    assign sum_ext   = 64'(sum_total);
    assign new_ext   = 64'(new_total);

    // parse one frame byte
    always_comb
    begin
        ether_next = ether_reg;
        ihl_next   = ihl_reg;
        iplen_next = iplen_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        thl_next   = thl_reg;
        case (offset_reg)
            16'd12: ether_next[15:8] = data_byte;
            16'd13: ether_next[7:0]  = data_byte;
            16'd14: ihl_next         = data_byte[3:0];
            16'd16: iplen_next[15:8] = data_byte;
            16'd17: iplen_next[7:0]  = data_byte;
            16'd23: proto_next       = data_byte;
            16'd26: src_next[31:24]  = data_byte;
            16'd27: src_next[23:16]  = data_byte;
            16'd28: src_next[15:8]   = data_byte;
            16'd29: src_next[7:0]    = data_byte;
            16'd30: dst_next[31:24]  = data_byte;
            16'd31: dst_next[23:16]  = data_byte;
            16'd32: dst_next[15:8]   = data_byte;
            16'd33: dst_next[7:0]    = data_byte;
            default: ;
        endcase
        tcp_at = tcphpm_pkg::ETH_HDR_BYTES + {10'd0, ihl_next, 2'b00};
        if (offset_reg == tcp_at)
        begin
            sport_next[15:8] = data_byte;
        end
        if (offset_reg == tcp_at + 16'd1)
        begin
            sport_next[7:0] = data_byte;
        end
        if (offset_reg == tcp_at + 16'd12)
        begin
            thl_next = data_byte[7:4];
        end
        ihl_bytes = {10'd0, ihl_next, 2'b00};
        thl_bytes = {10'd0, thl_next, 2'b00};
    end

    // sequence the command, the table scan and the result
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        ptr_next    = ptr_reg;
        offset_next = offset_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        hit_next    = hit_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        osrc_next   = osrc_reg;
        odst_next   = odst_reg;
        otot_next   = otot_reg;
        ovalid_next = ovalid_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg[AW-1:0];
        ram_wdata   = {key_reg, sum_total};
        ram_raddr   = ptr_reg[AW-1:0];

        case (state_reg)
            tcphpm_pkg::FSM_IDLE:
            begin
                ram_raddr = AW'(entry_index);
                if (accept && op == tcphpm_pkg::OP_READ)
                begin
                    hit_next   = (16'(entry_index) < 16'(TABLE_ENTRIES))
                              && (16'(entry_index) < 16'(used_reg));
                    state_next = tcphpm_pkg::FSM_READ_WAIT;
                end
                else if (accept)
                begin
                    if (last_byte)
                    begin
                        offset_next = 16'd0;
                        key_next    = {src_next, dst_next};
                        pay_next    = 18'(iplen_next) - 18'(ihl_bytes) - 18'(thl_bytes);
                        ptr_next    = '0;
                        if (offset_reg < tcphpm_pkg::ETH_HDR_BYTES
                            || ether_next != tcphpm_pkg::ETHERTYPE_IPV4
                            || proto_next != tcphpm_pkg::PROTO_TCP
                            || sport_next == 16'd0)
                        begin
                            done_next   = 1'b1;
                            status_next = tcphpm_pkg::ST_SKIPPED;
                            osrc_next   = '0;
                            odst_next   = '0;
                            otot_next   = '0;
                            ovalid_next = 1'b0;
                        end
                        else
                        begin
                            state_next = tcphpm_pkg::FSM_SCAN_RD;
                        end
                    end
                    else if (offset_reg != tcphpm_pkg::OFFSET_MAX)
                    begin
                        offset_next = offset_reg + 16'd1;
                    end
                end
            end

            tcphpm_pkg::FSM_READ_WAIT:
            begin
                done_next   = 1'b1;
                status_next = tcphpm_pkg::ST_READ;
                osrc_next   = hit_reg ? ram_rdata[RW-1 -: 32] : 32'd0;
                odst_next   = hit_reg ? ram_rdata[RW-33 -: 32] : 32'd0;
                otot_next   = hit_reg ? rd_ext[39:0] : 40'd0;
                ovalid_next = hit_reg;
                state_next  = tcphpm_pkg::FSM_IDLE;
            end

            tcphpm_pkg::FSM_SCAN_RD:
            begin
                if (ptr_reg == used_reg)
                begin
                    done_next  = 1'b1;
                    osrc_next  = key_reg[63:32];
                    odst_next  = key_reg[31:0];
                    state_next = tcphpm_pkg::FSM_IDLE;
                    if (used_reg == FULL_COUNT)
                    begin
                        status_next = tcphpm_pkg::ST_FULL;
                        otot_next   = '0;
                        ovalid_next = 1'b0;
                    end
                    else
                    begin
                        // append the pair at the fill count
                        ram_we      = 1'b1;
                        ram_wdata   = {key_reg, new_total};
                        used_next   = used_reg + CW'(1);
                        status_next = tcphpm_pkg::ST_ADDED;
                        otot_next   = new_ext[39:0];
                        ovalid_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = tcphpm_pkg::FSM_SCAN_CMP;
                end
            end

            tcphpm_pkg::FSM_SCAN_CMP:
            begin
                if (ram_rdata[RW-1:TOTAL_BITS] == key_reg)
                begin
                    // add the payload into the matching slot
                    ram_we      = 1'b1;
                    done_next   = 1'b1;
                    status_next = tcphpm_pkg::ST_UPDATED;
                    osrc_next   = key_reg[63:32];
                    odst_next   = key_reg[31:0];
                    otot_next   = sum_ext[39:0];
                    ovalid_next = 1'b1;
                    state_next  = tcphpm_pkg::FSM_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + CW'(1);
                    state_next = tcphpm_pkg::FSM_SCAN_RD;
                end
            end

            default:
            begin
                state_next = tcphpm_pkg::FSM_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tcphpm_pkg::FSM_IDLE;
            used_reg   <= '0;
            done_reg   <= 1'b0;
            offset_reg <= '0;
            ether_reg  <= '0;
            ihl_reg    <= '0;
            iplen_reg  <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            sport_reg  <= '0;
            thl_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            done_reg   <= done_next;
            offset_reg <= offset_next;
            if (accept && op == tcphpm_pkg::OP_BYTE)
            begin
                if (last_byte)
                begin
                    ether_reg <= '0;
                    ihl_reg   <= '0;
                    iplen_reg <= '0;
                    proto_reg <= '0;
                    src_reg   <= '0;
                    dst_reg   <= '0;
                    sport_reg <= '0;
                    thl_reg   <= '0;
                end
                else
                begin
                    ether_reg <= ether_next;
                    ihl_reg   <= ihl_next;
                    iplen_reg <= iplen_next;
                    proto_reg <= proto_next;
                    src_reg   <= src_next;
                    dst_reg   <= dst_next;
                    sport_reg <= sport_next;
                    thl_reg   <= thl_next;
                end
            end
        end
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        osrc_reg   <= osrc_next;
        odst_reg   <= odst_next;
        otot_reg   <= otot_next;
        ovalid_reg <= ovalid_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign src_addr    = osrc_reg;
    assign dst_addr    = odst_reg;
    assign byte_total  = otot_reg;
    assign entry_valid = ovalid_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL_COUNT)
        else $error("fill count past table size");

    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcphpm_pkg::FSM_SCAN_CMP |-> ptr_reg < used_reg)
        else $error("scan compares beyond filled slots");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == tcphpm_pkg::FSM_SCAN_RD
                || state_reg == tcphpm_pkg::FSM_SCAN_CMP)
        else $error("table write outside a scan");

    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> done && entry_valid)
        else $error("table write without a result beat");
`endif

endmodule
